[design/nct_pkg.sv]
`default_nettype none
package nct_pkg;
	localparam int TABLE_ENTRIES = 20;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W = 5;
	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [7:0] PROTO_TCP = 8'd6;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_DEL = 2'd1,
		OP_XLATE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REJECT = 2'd1,
		ST_MISS = 2'd2,
		ST_NOT_TCP = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLEAR,
		S_CSUM,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		CS_IP,
		CS_PORT,
		CS_TCP_IP
	} cs_step_t;

	// one checksum update step: wide selects 32-bit or 16-bit replacement
	typedef struct packed {
		logic        wide;
		logic [15:0] check;
		logic [31:0] oldv;
		logic [31:0] newv;
	} csum_req_t;
endpackage
`default_nettype wire

[design/nat_connection_table.sv]
`default_nettype none
// Channel  | Dir | Payload
// s_axis   | in  | op,dir,ip_version,protocol,ips,ports,checksums (tdata)
// m_axis   | out | status,slot,new_ip,new_port,checksums,hit_count (tdata)
// Flow: a rejected add or a non-TCP translate goes from idle straight to output;
//   clear passes through the clear state; a translate hit scans up to all 20
//   entries, one entry per cycle from the rover, then runs three checksum steps on
//   the shared checksum unit, then output and back to idle.
// Reset: arst_n clears the table valid bits, keys, counters and rover.
// Stalls: s_axis_tready is low while a request is in work or a result waits.
module nat_connection_table (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// op[1:0] dir[2] ip_version[6:3] protocol[14:7] src_ip[46:15] dst_ip[78:47]
	// sport[94:79] dport[110:95] ip_check[126:111] tcp_check[142:127]
	input  wire  [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// status[1:0] slot[6:2] new_ip[38:7] new_port[54:39] new_ip_check[70:55]
	// new_tcp_check[86:71] hit_count[118:87]
	output logic [119:0] m_axis_tdata
);
	import nct_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	logic              valid_q [TABLE_ENTRIES];
	logic [15:0]       key_q   [TABLE_ENTRIES];
	logic [31:0]       osrc_q  [TABLE_ENTRIES];
	logic [31:0]       rdst_q  [TABLE_ENTRIES];
	logic [15:0]       mport_q [TABLE_ENTRIES];
	logic [31:0]       rcnt_q  [TABLE_ENTRIES];
	logic [31:0]       ocnt_q  [TABLE_ENTRIES];
	logic [IDX_W-1:0]  rover_q;

	state_t state_q, state_d;
	logic [142:0] req_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W:0]   cnt_q;
	logic found_q;
	logic [IDX_W-1:0] hit_q;
	cs_step_t cs_q;
	logic [1:0]  status_q;
	logic [31:0] new_ip_q, hits_q;
	logic [15:0] new_port_q, nic_q, ntc_q;

	op_t op;
	logic dirr;
	logic [31:0] sip, dip;
	logic [15:0] sport, dport, key;
	logic match, scan_end;
	logic [IDX_W-1:0] idx_nx;
	csum_req_t cs_req;
	logic [15:0] cs_out;

	assign op    = op_t'(req_q[1:0]);
	assign dirr  = req_q[2];
	assign sip   = req_q[46:15];
	assign dip   = req_q[78:47];
	assign sport = req_q[94:79];
	assign dport = req_q[110:95];
	assign key   = (op == OP_XLATE && !dirr) ? sport : dport;
	assign idx_nx = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign match = (op == OP_ADD) ? !valid_q[idx_q] : (valid_q[idx_q] && key_q[idx_q] == key);
	assign scan_end = match || (cnt_q == (IDX_W+1)'(TABLE_ENTRIES - 1));

	always_comb begin
		cs_req.wide  = (cs_q != CS_PORT);
		cs_req.check = (cs_q == CS_IP) ? nic_q : ntc_q;
		cs_req.oldv  = (cs_q == CS_PORT) ? {16'd0, (dirr ? dport : sport)} : (dirr ? dip : sip);
		cs_req.newv  = (cs_q == CS_PORT) ? {16'd0, new_port_q} : new_ip_q;
	end

	nct_csum u_csum (.req(cs_req), .check(cs_out));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid) begin
				case (op_t'(s_axis_tdata[1:0]))
					OP_CLEAR: state_d = S_CLEAR;
					OP_ADD: state_d = (s_axis_tdata[94:79] != s_axis_tdata[110:95]) ? S_OUT : S_SCAN;
					OP_XLATE: state_d = (s_axis_tdata[6:3] != IPV4_VERSION
						|| s_axis_tdata[14:7] != PROTO_TCP) ? S_OUT : S_SCAN;
					default: state_d = S_SCAN;
				endcase
			end
			S_SCAN: if (scan_end) begin
				state_d = (op == OP_XLATE && match) ? S_CSUM : S_OUT;
			end
			S_CLEAR: state_d = S_OUT;
			S_CSUM: if (cs_q == CS_TCP_IP) begin
				state_d = S_OUT;
			end
			S_OUT: if (m_axis_tready) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		m_axis_tvalid = (state_q == S_OUT);
		m_axis_tdata = {1'b0, hits_q, ntc_q, nic_q, new_port_q, new_ip_q,
			(found_q ? SLOT_W'(hit_q) : SLOT_W'(0)), status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rover_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				key_q[i] <= '0;
				rcnt_q[i] <= '0;
				ocnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					req_q <= s_axis_tdata[142:0];
					idx_q <= rover_q;
					cnt_q <= '0;
					found_q <= 1'b0;
					new_ip_q <= '0;
					new_port_q <= '0;
					hits_q <= '0;
					nic_q <= s_axis_tdata[126:111];
					ntc_q <= s_axis_tdata[142:127];
					cs_q <= CS_IP;
					// reject a mismatched add and drop a non-TCP translate right away
					status_q <= (op_t'(s_axis_tdata[1:0]) == OP_ADD
						&& s_axis_tdata[94:79] != s_axis_tdata[110:95]) ? ST_REJECT
						: (op_t'(s_axis_tdata[1:0]) == OP_XLATE
						&& (s_axis_tdata[6:3] != IPV4_VERSION
						|| s_axis_tdata[14:7] != PROTO_TCP)) ? ST_NOT_TCP : ST_OK;
				end
				S_SCAN: begin
					idx_q <= idx_nx;
					cnt_q <= cnt_q + 1'b1;
					if (scan_end) begin
						case (op)
							OP_ADD: begin
								// take the free slot, or advance rover and overwrite
								hit_q <= match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1);
								found_q <= 1'b1;
								rover_q <= match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1);
								valid_q[match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1)] <= 1'b1;
								key_q[match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1)] <= dport;
								osrc_q[match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1)] <= sip;
								rdst_q[match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1)] <= dip;
								mport_q[match ? idx_q : ((rover_q == LAST) ? '0 : rover_q + 1'b1)] <= sport;
							end
							OP_DEL: if (match) begin
								hit_q <= idx_q;
								found_q <= 1'b1;
								valid_q[idx_q] <= 1'b0;
								key_q[idx_q] <= '0;
								rcnt_q[idx_q] <= '0;
								ocnt_q[idx_q] <= '0;
							end else begin
								status_q <= ST_MISS;
							end
							default: if (match) begin
								hit_q <= idx_q;
								found_q <= 1'b1;
								if (dirr) begin
									rcnt_q[idx_q] <= rcnt_q[idx_q] + 1'b1;
									hits_q <= rcnt_q[idx_q] + 1'b1;
									new_ip_q <= osrc_q[idx_q];
									new_port_q <= mport_q[idx_q];
								end else begin
									ocnt_q[idx_q] <= ocnt_q[idx_q] + 1'b1;
									hits_q <= ocnt_q[idx_q] + 1'b1;
									new_ip_q <= rdst_q[idx_q];
									new_port_q <= key_q[idx_q];
								end
							end else begin
								status_q <= ST_MISS;
							end
						endcase
					end
				end
				S_CLEAR: begin
					rover_q <= '0;
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						valid_q[i] <= 1'b0;
						key_q[i] <= '0;
						rcnt_q[i] <= '0;
						ocnt_q[i] <= '0;
					end
				end
				S_CSUM: begin
					// ip header for address, then tcp for port, then tcp for address
					case (cs_q)
						CS_IP: begin
							nic_q <= cs_out;
							cs_q <= CS_PORT;
						end
						CS_PORT: begin
							ntc_q <= cs_out;
							cs_q <= CS_TCP_IP;
						end
						default: ntc_q <= cs_out;
					endcase
				end
				default: ;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
	a_rover_range: assert property (@(posedge clk) disable iff (!arst_n)
		rover_q <= LAST) else $error("rover out of range");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule
`default_nettype wire

[design/nct_csum.sv]
`default_nettype none
// Shared ones-complement checksum update unit, one update per cycle.
module nct_csum (
	input  wire nct_pkg::csum_req_t req,
	output logic [15:0]             check
);
	import nct_pkg::*;

	logic [18:0] sum;
	logic [16:0] f1;
	logic [15:0] f2;

	always_comb begin
		sum = {3'b000, ~req.check} + {3'b000, ~req.oldv[15:0]} + 19'(req.newv[15:0]);
		if (req.wide) begin
			sum = sum + {3'b000, ~req.oldv[31:16]} + 19'(req.newv[31:16]);
		end
		f1 = 17'(sum[15:0]) + 17'(sum[18:16]);
		f2 = f1[15:0] + 16'(f1[16]);
		if (f2 == 16'd0) begin
			f2 = 16'hFFFF;
		end
		check = ~f2;
	end
endmodule
`default_nettype wire

[verif/nct_checker.sv]
`timescale 1ns / 100ps
module nct_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	input  wire          s_axis_tready,
	input  wire  [143:0] s_axis_tdata,
	input  wire          m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire  [119:0] m_axis_tdata,
	output int           fail_count,
	output int           pending
);
	import nct_pkg::*;

	typedef struct packed {
		logic [31:0] hit_count;
		logic [15:0] new_tcp_check;
		logic [15:0] new_ip_check;
		logic [15:0] new_port;
		logic [31:0] new_ip;
		logic [4:0]  slot;
		status_t     status;
	} xlate_result_t;

	logic        tbl_valid [TABLE_ENTRIES];
	logic [15:0] tbl_key [TABLE_ENTRIES];
	logic [31:0] tbl_orig_ip [TABLE_ENTRIES];
	logic [31:0] tbl_reply_ip [TABLE_ENTRIES];
	logic [15:0] tbl_mapped [TABLE_ENTRIES];
	logic [31:0] tbl_reply_cnt [TABLE_ENTRIES];
	logic [31:0] tbl_orig_cnt [TABLE_ENTRIES];
	int          rover;
	xlate_result_t expected_results[$];

	function automatic logic [15:0] csum_fix(logic [15:0] check, logic [31:0] oldv,
			logic [31:0] newv, bit wide);
		logic [31:0] s;
		s = {16'd0, ~check} + {16'd0, ~oldv[15:0]} + {16'd0, newv[15:0]};
		if (wide)
			s += {16'd0, ~oldv[31:16]} + {16'd0, newv[31:16]};
		s = (s & 32'hFFFF) + (s >> 16);
		s = (s & 32'hFFFF) + (s >> 16);
		if (s == 0)
			s = 32'hFFFF;
		return ~s[15:0];
	endfunction

	function automatic int find_slot(logic [15:0] key);
		int idx;
		for (int n = 0; n < TABLE_ENTRIES; n++) begin
			idx = (rover + n) % TABLE_ENTRIES;
			if (tbl_valid[idx] && tbl_key[idx] == key)
				return idx;
		end
		return -1;
	endfunction

	function automatic void clear_all();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 0;
			tbl_key[i] = 0;
			tbl_reply_cnt[i] = 0;
			tbl_orig_cnt[i] = 0;
		end
		rover = 0;
	endfunction

	// apply one request to the shadow table and return its result
	function automatic xlate_result_t apply_request(logic [143:0] d);
		xlate_result_t r;
		op_t         op;
		logic        dir;
		logic [31:0] sip, dip, old_ip;
		logic [15:0] sport, dport, old_port;
		int          k;
		bit          found;
		op = op_t'(d[1:0]);
		dir = d[2];
		sip = d[46:15];
		dip = d[78:47];
		sport = d[94:79];
		dport = d[110:95];
		r = '0;
		r.status = ST_OK;
		r.new_ip_check = d[126:111];
		r.new_tcp_check = d[142:127];
		case (op)
			OP_ADD: begin
				if (sport != dport) begin
					r.status = ST_REJECT;
				end else begin
					found = 0;
					k = rover;
					for (int n = 0; n < TABLE_ENTRIES && !found; n++) begin
						k = (rover + n) % TABLE_ENTRIES;
						if (!tbl_valid[k])
							found = 1;
					end
					if (!found)
						k = (rover + 1) % TABLE_ENTRIES;
					rover = k;
					tbl_valid[k] = 1;
					tbl_key[k] = dport;
					tbl_orig_ip[k] = sip;
					tbl_reply_ip[k] = dip;
					tbl_mapped[k] = sport;
					r.slot = k[4:0];
				end
			end
			OP_DEL: begin
				k = find_slot(dport);
				if (k < 0) begin
					r.status = ST_MISS;
				end else begin
					tbl_valid[k] = 0;
					tbl_key[k] = 0;
					tbl_reply_cnt[k] = 0;
					tbl_orig_cnt[k] = 0;
					r.slot = k[4:0];
				end
			end
			OP_XLATE: begin
				if (d[6:3] != IPV4_VERSION || d[14:7] != PROTO_TCP) begin
					r.status = ST_NOT_TCP;
				end else begin
					k = find_slot(dir ? dport : sport);
					if (k < 0) begin
						r.status = ST_MISS;
					end else begin
						r.slot = k[4:0];
						if (dir) begin
							tbl_reply_cnt[k]++;
							r.hit_count = tbl_reply_cnt[k];
							r.new_ip = tbl_orig_ip[k];
							r.new_port = tbl_mapped[k];
							old_ip = dip;
							old_port = dport;
						end else begin
							tbl_orig_cnt[k]++;
							r.hit_count = tbl_orig_cnt[k];
							r.new_ip = tbl_reply_ip[k];
							r.new_port = tbl_key[k];
							old_ip = sip;
							old_port = sport;
						end
						r.new_ip_check = csum_fix(r.new_ip_check, old_ip, r.new_ip, 1);
						r.new_tcp_check = csum_fix(r.new_tcp_check, {16'd0, old_port},
							{16'd0, r.new_port}, 0);
						r.new_tcp_check = csum_fix(r.new_tcp_check, old_ip, r.new_ip, 1);
					end
				end
			end
			default: clear_all();
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		xlate_result_t got, want;
		if (!arst_n) begin
			clear_all();
			expected_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_request(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[118:0];
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_axis_tdata[119] !== 1'b0) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp st=%0d slot=%0d ip=%h port=%h",
								" ic=%h tc=%h hc=%h / got st=%0d slot=%0d ip=%h",
								" port=%h ic=%h tc=%h hc=%h"},
								want.status, want.slot, want.new_ip, want.new_port,
								want.new_ip_check, want.new_tcp_check, want.hit_count,
								got.status, got.slot, got.new_ip, got.new_port,
								got.new_ip_check, got.new_tcp_check, got.hit_count);
					end
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
module tb;
	import nct_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	// op, dir, ip_version, protocol, src_ip, dst_ip, sport, dport,
	// ip_check, tcp_check from bit 0 up
	logic [143:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	// status, slot, new_ip, new_port, new_ip_check, new_tcp_check, hit_count
	logic [119:0] m_axis_tdata;
	int           fail_count;
	int           pending;
	bit           stim_done = 0;
	bit           hold_off = 0;
	int unsigned  port_pool [8];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	nat_connection_table u_top (.*);

	nct_checker u_chk (.*);

	// send one request after a random gap; fields are cut to width when packed
	task automatic send_request(op_t op, int unsigned dir, int unsigned ver,
			int unsigned proto, int unsigned sip, int unsigned dip, int unsigned sport,
			int unsigned dport, int unsigned ic, int unsigned tc);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {1'b0, 16'(tc), 16'(ic), 16'(dport), 16'(sport), dip, sip,
			8'(proto), 4'(ver), 1'(dir), op};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// random request, mostly well-formed against a small pool of ports
	task automatic random_request();
		int          sel;
		int unsigned p, q;
		sel = $urandom_range(0, 99);
		p = port_pool[$urandom_range(0, 7)];
		q = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : p;
		if (sel < 30)
			send_request(OP_ADD, 0, 4, 6, $urandom, $urandom, p,
				$urandom_range(0, 9) == 0 ? $urandom : p, $urandom, $urandom);
		else if (sel < 40)
			send_request(OP_DEL, 0, 4, 6, $urandom, $urandom, $urandom, q,
				$urandom, $urandom);
		else if (sel < 90)
			send_request(OP_XLATE, $urandom, $urandom_range(0, 9) == 0 ? $urandom : 4,
				$urandom_range(0, 9) == 0 ? $urandom : 6, $urandom, $urandom,
				$urandom_range(0, 1) ? q : $urandom, q, $urandom, $urandom);
		else if (sel < 92)
			send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		else
			send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// receiver: random stalls, plus one long hold-off when requested
	initial begin
		int wait_cycles;
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				held = 1;
				m_axis_tready <= 0;
				repeat (300) @(negedge clk);
			end
			wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
			if (wait_cycles > 0) begin
				m_axis_tready <= 0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		for (int i = 0; i < 8; i++)
			port_pool[i] = $urandom_range(0, 65535);
		port_pool[0] = 0;
		port_pool[1] = 'hFFFF;
		// directed: extremes, every op, rejects, misses, non-TCP, fill and wrap
		send_request(OP_XLATE, 1, 4, 6, 0, 0, 0, 0, 0, 0);
		send_request(OP_DEL, 0, 0, 0, 0, 0, 0, 'hFFFF, 0, 0);
		send_request(OP_ADD, 0, 4, 6, 'h0, 'hFFFF_FFFF, 'h1234, 'h1235, 0, 0);
		send_request(OP_ADD, 0, 4, 6, 'hFFFF_FFFF, 'h0, 'hFFFF, 'hFFFF, 'hFFFF,
			'hFFFF);
		send_request(OP_ADD, 0, 4, 6, 'hC0A8_0001, 'h0A00_0001, 0, 0, 0, 0);
		send_request(OP_XLATE, 1, 4, 6, 'h1, 'hFFFF_FFFF, 'h5, 'hFFFF, 'h0,
			'hFFFF);
		send_request(OP_XLATE, 0, 4, 6, 'hFFFF_FFFF, 'h0, 'hFFFF, 'h7, 'hFFFF,
			'h0);
		send_request(OP_XLATE, 0, 4, 6, 0, 0, 0, 0, 0, 0);
		send_request(OP_XLATE, 1, 4, 17, 0, 0, 0, 0, 'hABCD, 'h1234);
		send_request(OP_XLATE, 1, 6, 6, 0, 0, 0, 0, 'hABCD, 'h1234);
		send_request(OP_XLATE, 1, 4, 6, 0, 0, 0, 'h4242, 'h5555, 'hAAAA);
		send_request(OP_DEL, 0, 4, 6, 0, 0, 0, 'hFFFF, 0, 0);
		for (int i = 0; i < 22; i++)
			send_request(OP_ADD, 0, 4, 6, $urandom, $urandom, i + 100, i + 100, 0, 0);
		send_request(OP_XLATE, 1, 4, 6, 0, 0, 0, 101, 0, 0);
		send_request(OP_CLEAR, 1, 15, 255, 0, 0, 0, 0, 0, 0);
		send_request(OP_XLATE, 1, 4, 6, 0, 0, 0, 110, 0, 0);
		// random part with one long output hold-off in the middle
		for (int i = 0; i < 700; i++) begin
			if (i == 350)
				hold_off = 1;
			random_request();
		end
		s_axis_tvalid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
